// ===== rtl/core/fsbm_pkg.sv =====
// Shared constants, types and the slant cost table for the font style matcher.
package fsbm_pkg;

    localparam int MAX_SET = 64;
    localparam int POS_W   = $clog2(MAX_SET + 1);
    localparam int IDX_W   = (MAX_SET > 1) ? $clog2(MAX_SET) : 1;
    localparam int SCORE_W = 28;

    localparam logic [SCORE_W-1:0] SCORE_MASK = {SCORE_W{1'b1}};

    localparam logic [3:0] WIDTH_NORMAL  = 4'd5;
    localparam logic [4:0] WIDTH_PENALTY = 5'(9 / 2 + 1);

    localparam logic [9:0]  WEIGHT_NORMAL  = 10'd400;
    localparam logic [9:0]  WEIGHT_MEDIUM  = 10'd500;
    localparam logic [10:0] WEIGHT_PENALTY = 11'(1000 / 2);
    localparam logic [10:0] WEIGHT_NEAR    = 11'd50;

    localparam logic [1:0] SLANT_UPRIGHT = 2'd0;
    localparam logic [1:0] SLANT_ITALIC  = 2'd1;
    localparam logic [1:0] SLANT_OBLIQUE = 2'd2;

    typedef logic [SCORE_W-1:0] t_score;

    // Scored candidate handed from the input stage to the tracker.
    typedef struct packed {
        logic   last;
        t_score score;
    } t_cand;

    // Running state visible to the top level.
    typedef struct packed {
        logic             seen_any;
        logic [POS_W-1:0] position;
    } t_trk_status;

    // Slant cost, indexed by wanted then candidate slant; both must be valid codes.
    function automatic logic [1:0] slant_cost(input logic [1:0] ws, input logic [1:0] cs);
        logic [1:0] cost;
        cost = 2'd0;
        case (ws)
            SLANT_UPRIGHT: begin
                case (cs)
                    SLANT_ITALIC:  cost = 2'd2;
                    SLANT_OBLIQUE: cost = 2'd1;
                    default:       cost = 2'd0;
                endcase
            end
            SLANT_ITALIC: begin
                case (cs)
                    SLANT_UPRIGHT: cost = 2'd2;
                    SLANT_OBLIQUE: cost = 2'd1;
                    default:       cost = 2'd0;
                endcase
            end
            default: begin
                case (cs)
                    SLANT_UPRIGHT: cost = 2'd2;
                    SLANT_ITALIC:  cost = 2'd1;
                    default:       cost = 2'd0;
                endcase
            end
        endcase
        return cost;
    endfunction

endpackage

// ===== rtl/core/fsbm_score.sv =====
// Combinational packed score of one candidate against the wanted style.
module fsbm_score (
    input  logic [3:0]      i_want_width,
    input  logic [9:0]      i_want_weight,
    input  logic [1:0]      i_want_slant,
    input  logic [3:0]      i_cand_width,
    input  logic [9:0]      i_cand_weight,
    input  logic [1:0]      i_cand_slant,
    output fsbm_pkg::t_score o_score
);
    import fsbm_pkg::*;

    logic [4:0]  width_cost;
    logic [10:0] weight_cost;
    logic [1:0]  slant_c;
    logic [28:0] raw;
    logic        slant_bad;

    always_comb begin
        if (i_want_width <= WIDTH_NORMAL) begin
            if (i_cand_width <= i_want_width)
                width_cost = 5'(i_want_width - i_cand_width);
            else
                width_cost = 5'(i_cand_width) - 5'(i_want_width) + WIDTH_PENALTY;
        end else begin
            if (i_cand_width >= i_want_width)
                width_cost = 5'(i_cand_width - i_want_width);
            else
                width_cost = 5'(i_want_width) - 5'(i_cand_width) + WIDTH_PENALTY;
        end
    end

    always_comb begin
        if ((i_want_weight == WEIGHT_NORMAL && i_cand_weight == WEIGHT_MEDIUM) ||
            (i_want_weight == WEIGHT_MEDIUM && i_cand_weight == WEIGHT_NORMAL)) begin
            weight_cost = WEIGHT_NEAR;
        end else if (i_want_weight <= WEIGHT_NORMAL) begin
            if (i_cand_weight <= i_want_weight)
                weight_cost = 11'(i_want_weight - i_cand_weight);
            else
                weight_cost = 11'(i_cand_weight) - 11'(i_want_weight) + WEIGHT_PENALTY;
        end else begin
            if (i_cand_weight >= i_want_weight)
                weight_cost = 11'(i_cand_weight - i_want_weight);
            else
                weight_cost = 11'(i_want_weight) - 11'(i_cand_weight) + WEIGHT_PENALTY;
        end
    end

    assign slant_bad = (i_want_slant > SLANT_OBLIQUE) || (i_cand_slant > SLANT_OBLIQUE);
    assign slant_c   = slant_cost(i_want_slant, i_cand_slant);

    // Fields never overlap: width at 24, slant at 16, weight below 2^11.
    assign raw = {width_cost, 6'b0, slant_c, 5'b0, weight_cost};

    always_comb begin
        if (slant_bad)
            o_score = '0;
        else if (raw[28])
            o_score = SCORE_MASK;
        else
            o_score = raw[27:0];
    end

endmodule

// ===== rtl/core/fsbm_track.sv =====
// Running strict minimum over a set and the registered result stage.
module fsbm_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  fsbm_pkg::t_cand               i_cand,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [fsbm_pkg::IDX_W-1:0]    o_best_index,
    output fsbm_pkg::t_score              o_best_score,
    output fsbm_pkg::t_trk_status         o_status
);
    import fsbm_pkg::*;

    logic             r_seen;
    logic [POS_W-1:0] r_pos;
    t_score           r_min;
    logic [IDX_W-1:0] r_best;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    t_score           r_out_score;

    logic             in_range;
    logic             take;
    t_score           n_min;
    logic [IDX_W-1:0] n_best;

    assign in_range = r_pos < POS_W'(MAX_SET);
    assign take     = in_range && (!r_seen || i_cand.score < r_min);
    assign n_min    = take ? i_cand.score : r_min;
    assign n_best   = take ? r_pos[IDX_W-1:0] : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_pos  <= '0;
            r_min  <= SCORE_MASK;
            r_best <= '0;
        end else if (i_adv) begin
            if (i_cand.last) begin
                r_seen <= 1'b0;
                r_pos  <= '0;
                r_min  <= SCORE_MASK;
                r_best <= '0;
            end else if (in_range) begin
                r_seen <= 1'b1;
                r_pos  <= r_pos + 1'b1;
                r_min  <= n_min;
                r_best <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv && i_cand.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_cand.last) begin
            r_out_index <= n_best;
            r_out_score <= n_min;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_best_index      = r_out_index;
    assign o_best_score      = r_out_score;
    assign o_status.seen_any = r_seen;
    assign o_status.position = r_pos;

endmodule

// ===== rtl/core/font_style_best_match.sv =====
// Top level of the font style matcher: input register, scorer and running-minimum tracker.
//
// Each transfer on the input channel carries one candidate style and the wanted style; the
// candidate is scored and folded into a running strict minimum, so the earliest of equal
// scores wins. The transfer marked set_last produces one result: the index of the best
// candidate within its set and its packed score (width distance at bit 24, slant at 16,
// weight below), saturated to 28 bits, or zero when either slant code is invalid.
// Candidates past the 64th of a set are ignored but their set_last still closes the set.
// The path to the earliest result transfer runs through the input register, where the score
// is formed, and the result register, which is loaded when the closing item leaves the input
// register. One item is taken every cycle; the input stalls only when a set-closing item
// waits for a result register that is still held by a stalled output.
module font_style_best_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [3:0]                  i_want_width,
    input  logic [9:0]                  i_want_weight,
    input  logic [1:0]                  i_want_slant,
    input  logic [3:0]                  i_cand_width,
    input  logic [9:0]                  i_cand_weight,
    input  logic [1:0]                  i_cand_slant,
    input  logic                        i_set_last,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [fsbm_pkg::IDX_W-1:0]  o_best_index,
    output fsbm_pkg::t_score            o_best_score
);
    import fsbm_pkg::*;

    // Input register stage.
    logic        r_s1_valid;
    logic [3:0]  r_want_width;
    logic [9:0]  r_want_weight;
    logic [1:0]  r_want_slant;
    logic [3:0]  r_cand_width;
    logic [9:0]  r_cand_weight;
    logic [1:0]  r_cand_slant;
    logic        r_s1_last;

    t_score      score;
    t_cand       cand;
    t_trk_status status;
    logic        out_free;
    logic        s1_adv;
    logic        in_xfer;

    // The result slot is free when empty or being drained this cycle.
    assign out_free = !o_valid || !i_stall;
    // Non-final items fold into the tracker regardless of the output side.
    assign s1_adv   = r_s1_valid && (!r_s1_last || out_free);
    // Hold the input while the staged item cannot advance.
    assign o_stall  = r_s1_valid && !s1_adv;
    assign in_xfer  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_want_width  <= i_want_width;
            r_want_weight <= i_want_weight;
            r_want_slant  <= i_want_slant;
            r_cand_width  <= i_cand_width;
            r_cand_weight <= i_cand_weight;
            r_cand_slant  <= i_cand_slant;
            r_s1_last     <= i_set_last;
        end
    end

    fsbm_score u_score (
        .i_want_width  (r_want_width),
        .i_want_weight (r_want_weight),
        .i_want_slant  (r_want_slant),
        .i_cand_width  (r_cand_width),
        .i_cand_weight (r_cand_weight),
        .i_cand_slant  (r_cand_slant),
        .o_score       (score)
    );

    assign cand.last  = r_s1_last;
    assign cand.score = score;

    fsbm_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (s1_adv),
        .i_cand       (cand),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_best_index (o_best_index),
        .o_best_score (o_best_score),
        .o_status     (status)
    );

    // The tracker has seen a candidate exactly when its position has moved.
    a_seen_matches_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.seen_any == (status.position != '0))
        else $error("seen flag disagrees with set position");

    // Input stalls only for a set-closing item blocked by a held result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_last && o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Closing a set presents a result and clears the running state.
    a_set_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && r_s1_last) |=> (o_valid && status.position == '0 && !status.seen_any))
        else $error("set close did not produce a result and clear state");

endmodule
